### design/ttl_pkg.sv
// shared types, character constants and classification functions for the token lexer
`default_nettype none

package ttl_pkg;

	localparam int KIND_BITS = 4;
	localparam int START_BITS = 16;
	localparam int LEN_BITS = 12;
	localparam int LEN_LIMIT = 4095;

	localparam logic [KIND_BITS-1:0] KIND_END = 4'd10;
	localparam logic [KIND_BITS-1:0] KIND_STRING = 4'd11;
	localparam logic [KIND_BITS-1:0] KIND_IDENT = 4'd12;
	localparam logic [KIND_BITS-1:0] KIND_NUMBER = 4'd13;
	localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 4'd14;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [START_BITS-1:0] start;
		logic [LEN_BITS-1:0] len;
		logic unterm;
		logic clipped;
		logic last;
	} result_t;

	typedef struct packed {
		logic hit;
		logic [KIND_BITS-1:0] kind;
	} punct_t;

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || is_eol(c);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// punctuation index in the order { } ( ) [ ] = , # ;
	function automatic punct_t punct_lookup(input logic [7:0] c);
		punct_t p;
		p.hit = 1'b1;
		p.kind = '0;
		unique case (c)
			8'h7B: p.kind = 4'd0;
			8'h7D: p.kind = 4'd1;
			8'h28: p.kind = 4'd2;
			8'h29: p.kind = 4'd3;
			8'h5B: p.kind = 4'd4;
			8'h5D: p.kind = 4'd5;
			8'h3D: p.kind = 4'd6;
			8'h2C: p.kind = 4'd7;
			CH_HASH: p.kind = 4'd8;
			CH_SEMI: p.kind = 4'd9;
			default: p.hit = 1'b0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### design/text_token_lexer.sv
// streaming lexer top level: byte classification, token state and result queue
`default_nettype none

// Takes one byte of source text per cycle while char_ready is high and emits tokens
// with kind, start offset and length. Each accepted byte is classified and the token
// state updated in the same cycle; the results (none, one or two) go into a four-entry
// queue whose head drives the outputs. Bytes are accepted every cycle while at most
// two entries are occupied, so a stream of at most one token per byte runs at one
// byte per cycle while token_ready is high; a byte that closes one token and forms
// another yields two queue results. Bytes past end of stream are taken and dropped.
module text_token_lexer #(
	parameter int OFFSET_BITS = 16,
	parameter int MAX_TOKEN_LENGTH = 4095
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic char_valid,
	output logic char_ready,
	input wire logic [7:0] char_byte,
	output logic token_valid,
	input wire logic token_ready,
	output logic [ttl_pkg::KIND_BITS-1:0] token_kind,
	output logic [ttl_pkg::START_BITS-1:0] start_offset,
	output logic [ttl_pkg::LEN_BITS-1:0] token_length,
	output logic unterminated,
	output logic length_clipped,
	output logic last_of_run
);
	import ttl_pkg::*;

	localparam logic [LEN_BITS-1:0] LEN_CAP =
		LEN_BITS'((MAX_TOKEN_LENGTH < LEN_LIMIT) ? MAX_TOKEN_LENGTH : LEN_LIMIT);
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		M_IDLE,
		M_STRING,
		M_IDENT,
		M_NUMBER,
		M_UNKNOWN
	} mode_t;

	mode_t mode_q, mode_d;
	logic [START_BITS-1:0] open_start_q, open_start_d;
	logic [LEN_BITS-1:0] open_len_q, open_len_d;
	logic open_clip_q, open_clip_d;
	logic [OFFSET_BITS-1:0] offset_q;
	logic ended_q, ended_d;

	result_t queue_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0] count_q;

	logic accept, pop;
	logic [31:0] off_ext;
	logic [START_BITS-1:0] off16;
	logic [LEN_BITS-1:0] grown_len;
	logic grown_clip;
	logic do_close, do_start, do_grow, close_grown, close_unterm;
	logic [KIND_BITS-1:0] close_kind;
	logic start_emit, start_open;
	mode_t start_mode;
	logic [KIND_BITS-1:0] start_kind;
	punct_t punct;
	result_t res0, res1;
	logic [1:0] n_res;

	assign accept = char_valid && char_ready;
	assign pop = token_valid && token_ready;
	assign char_ready = (count_q <= (QPTR_BITS+1)'(QDEPTH - 2));
	assign token_valid = (count_q != '0);

	assign off_ext = 32'(offset_q);
	assign off16 = off_ext[START_BITS-1:0];

	assign grown_len = (open_len_q < LEN_CAP) ? open_len_q + 1'b1 : open_len_q;
	assign grown_clip = open_clip_q || (open_len_q >= LEN_CAP);
	assign punct = punct_lookup(char_byte);

	// classification of a byte that begins a token
	always_comb begin
		start_emit = 1'b0;
		start_open = 1'b0;
		start_mode = M_IDLE;
		start_kind = '0;
		priority if (is_blank(char_byte)) begin
			start_emit = 1'b0;
		end else if (char_byte == CH_NUL) begin
			start_emit = 1'b1;
			start_kind = KIND_END;
		end else if (punct.hit) begin
			start_emit = 1'b1;
			start_kind = punct.kind;
		end else if (char_byte == CH_QUOTE) begin
			start_open = 1'b1;
			start_mode = M_STRING;
		end else if (is_letter(char_byte)) begin
			start_open = 1'b1;
			start_mode = M_IDENT;
		end else if (is_digit(char_byte) || char_byte == CH_MINUS) begin
			start_open = 1'b1;
			start_mode = M_NUMBER;
		end else begin
			start_open = 1'b1;
			start_mode = M_UNKNOWN;
		end
	end

	// mode update for the open token
	always_comb begin
		do_close = 1'b0;
		do_start = 1'b0;
		do_grow = 1'b0;
		close_grown = 1'b0;
		close_unterm = 1'b0;
		close_kind = KIND_STRING;
		unique case (mode_q)
			M_STRING: begin
				close_kind = KIND_STRING;
				if (char_byte == CH_QUOTE) begin
					do_close = 1'b1;
					close_grown = 1'b1;
				end else if (char_byte == CH_NUL) begin
					do_close = 1'b1;
					close_unterm = 1'b1;
					do_start = 1'b1;
				end else begin
					do_grow = 1'b1;
				end
			end
			M_IDENT: begin
				close_kind = KIND_IDENT;
				if (is_letter(char_byte) || is_digit(char_byte)
						|| char_byte == CH_UNDERSCORE) begin
					do_grow = 1'b1;
				end else begin
					do_close = 1'b1;
					do_start = 1'b1;
				end
			end
			M_NUMBER: begin
				close_kind = KIND_NUMBER;
				if (is_digit(char_byte) || char_byte == CH_DOT) begin
					do_grow = 1'b1;
				end else begin
					do_close = 1'b1;
					do_start = 1'b1;
				end
			end
			M_UNKNOWN: begin
				close_kind = KIND_UNKNOWN;
				if (is_eol(char_byte)) begin
					do_close = 1'b1;
				end else if (char_byte == CH_NUL) begin
					do_close = 1'b1;
					close_unterm = 1'b1;
					do_start = 1'b1;
				end else begin
					do_grow = 1'b1;
				end
			end
			default: begin
				do_start = 1'b1;
			end
		endcase
	end

	// results and next state
	always_comb begin
		result_t close_res, start_res;
		close_res.kind = close_kind;
		close_res.start = open_start_q;
		close_res.len = close_grown ? grown_len : open_len_q;
		close_res.unterm = close_unterm;
		close_res.clipped = close_grown ? grown_clip : open_clip_q;
		close_res.last = !(do_start && start_emit);
		start_res.kind = start_kind;
		start_res.start = off16;
		start_res.len = LEN_BITS'(1);
		start_res.unterm = 1'b0;
		start_res.clipped = 1'b0;
		start_res.last = 1'b1;

		res0 = do_close ? close_res : start_res;
		res1 = start_res;
		n_res = 2'(do_close) + 2'(do_start && start_emit);

		mode_d = mode_q;
		open_start_d = open_start_q;
		open_len_d = open_len_q;
		open_clip_d = open_clip_q;
		ended_d = ended_q || (do_start && char_byte == CH_NUL);
		if (do_start && start_open) begin
			mode_d = start_mode;
			open_start_d = off16;
			open_len_d = LEN_BITS'(1);
			open_clip_d = 1'b0;
		end else if (do_close || do_start) begin
			mode_d = M_IDLE;
			open_len_d = '0;
			open_clip_d = 1'b0;
		end else if (do_grow) begin
			open_len_d = grown_len;
			open_clip_d = grown_clip;
		end
		if (ended_q) begin
			n_res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			open_start_q <= '0;
			open_len_q <= '0;
			open_clip_q <= 1'b0;
			offset_q <= '0;
			ended_q <= 1'b0;
		end else if (accept && !ended_q) begin
			mode_q <= mode_d;
			open_start_q <= open_start_d;
			open_len_q <= open_len_d;
			open_clip_q <= open_clip_d;
			offset_q <= offset_q + 1'b1;
			ended_q <= ended_d;
		end
	end

	// result queue: up to two results written per accepted byte, at most one read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			logic [1:0] n_push;
			n_push = accept ? n_res : 2'd0;
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_BITS+1)'(n_push) - (QPTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
			if (n_res == 2'd2) begin
				queue_q[wr_ptr_q + 1'b1] <= res1;
			end
		end
	end

	always_comb begin
		result_t head;
		head = queue_q[rd_ptr_q];
		token_kind = head.kind;
		start_offset = head.start;
		token_length = head.len;
		unterminated = head.unterm;
		length_clipped = head.clipped;
		last_of_run = head.last;
	end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// testbench for text_token_lexer: byte stream driver, token predictor and result checker
`timescale 1ns / 1ps

module tb_top;

	localparam int OFFSET_BITS = 16;
	localparam int MAX_TOKEN_LENGTH = 4095;
	localparam int LEN_CAP = (MAX_TOKEN_LENGTH < 4095) ? MAX_TOKEN_LENGTH : 4095;
	localparam int RANDOM_BYTES = 950;
	localparam int DRAIN_CYCLES = 40;
	localparam int LEN_BITS = ttl_pkg::LEN_BITS;
	localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

	// punctuation kind is the position in this string
	localparam logic [79:0] PUNCT_SET = "{}()[]=,#;";

	typedef enum logic [2:0] {
		LEX_IDLE,
		LEX_STRING,
		LEX_IDENT,
		LEX_NUMBER,
		LEX_UNKNOWN
	} lex_state_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic [7:0] char_byte = '0;
	logic token_ready = 1'b0;
	logic char_ready;
	logic token_valid;
	logic [ttl_pkg::KIND_BITS-1:0] token_kind;
	logic [ttl_pkg::START_BITS-1:0] start_offset;
	logic [ttl_pkg::LEN_BITS-1:0] token_length;
	logic unterminated;
	logic length_clipped;
	logic last_of_run;

	// bytes waiting to be sent and tokens waiting to come out
	logic [7:0] text_bytes[$];
	ttl_pkg::result_t tokens_due[$];

	// predicted lexer state
	lex_state_e lex_state = LEX_IDLE;
	logic [OFFSET_BITS-1:0] tok_start = '0;
	logic [OFFSET_BITS-1:0] scan_pos = '0;
	logic [ttl_pkg::LEN_BITS-1:0] tok_len = '0;
	bit tok_clipped = 1'b0;
	bit stream_done = 1'b0;
	ttl_pkg::result_t held;
	bit have_held = 1'b0;

	int send_wait;
	int take_wait;
	int calm_in;
	int calm_out;
	int stall;
	int mismatch_count = 0;
	ttl_pkg::result_t got;
	ttl_pkg::result_t want;

	text_token_lexer #(
		.OFFSET_BITS(OFFSET_BITS),
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_byte(char_byte),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_kind(token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.unterminated(unterminated),
		.length_clipped(length_clipped),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bit is_eol(input logic [7:0] c);
		return c == ttl_pkg::CH_LF || c == ttl_pkg::CH_CR;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == ttl_pkg::CH_SPACE || c == ttl_pkg::CH_TAB || is_eol(c);
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int punct_kind(input logic [7:0] c);
		for (int i = 0; i < 10; i++)
			if (PUNCT_SET[79-8*i -: 8] == c)
				return i;
		return -1;
	endfunction

	// mostly short gaps, now and then a long one, none during a calm stretch
	function automatic int pick_gap(input int calm);
		int r;
		if (calm > 0)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 50)
			return 0;
		if (r < 85)
			return int'($urandom_range(1, 3));
		if (r < 97)
			return int'($urandom_range(4, 10));
		return int'($urandom_range(20, 60));
	endfunction

	// ---------------- token predictor ----------------

	// the final token of a byte is only known once the byte is done, so one is held back
	task automatic emit(input logic [3:0] kind, input logic [OFFSET_BITS-1:0] start,
			input logic [ttl_pkg::LEN_BITS-1:0] len, input bit unterm, input bit clip);
		ttl_pkg::result_t r;
		r.kind = kind;
		r.start = start;
		r.len = len;
		r.unterm = unterm;
		r.clipped = clip;
		r.last = 1'b0;
		if (have_held)
			tokens_due.push_back(held);
		held = r;
		have_held = 1'b1;
	endtask

	task automatic grow_tok();
		if (tok_len < LEN_CAP)
			tok_len = tok_len + 1'b1;
		else
			tok_clipped = 1'b1;
	endtask

	task automatic open_tok(input lex_state_e st, input logic [OFFSET_BITS-1:0] off);
		lex_state = st;
		tok_start = off;
		tok_len = LEN_ONE;
		tok_clipped = 1'b0;
	endtask

	task automatic close_tok(input logic [3:0] kind, input bit unterm);
		emit(kind, tok_start, tok_len, unterm, tok_clipped);
		lex_state = LEX_IDLE;
		tok_len = '0;
		tok_clipped = 1'b0;
	endtask

	task automatic begin_token(input logic [7:0] c, input logic [OFFSET_BITS-1:0] off);
		int p;
		p = punct_kind(c);
		if (!is_blank(c)) begin
			if (c == ttl_pkg::CH_NUL) begin
				stream_done = 1'b1;
				emit(ttl_pkg::KIND_END, off, LEN_ONE, 1'b0, 1'b0);
			end else if (p >= 0)
				emit(4'(p), off, LEN_ONE, 1'b0, 1'b0);
			else if (c == ttl_pkg::CH_QUOTE)
				open_tok(LEX_STRING, off);
			else if (is_letter(c))
				open_tok(LEX_IDENT, off);
			else if (is_digit(c) || c == ttl_pkg::CH_MINUS)
				open_tok(LEX_NUMBER, off);
			else
				open_tok(LEX_UNKNOWN, off);
		end
	endtask

	task automatic lex_byte(input logic [7:0] c);
		logic [OFFSET_BITS-1:0] off;
		off = scan_pos;
		if (!stream_done) begin
			scan_pos = scan_pos + 1'b1;
			case (lex_state)
				LEX_STRING: begin
					if (c == ttl_pkg::CH_QUOTE) begin
						grow_tok();
						close_tok(ttl_pkg::KIND_STRING, 1'b0);
					end else if (c == ttl_pkg::CH_NUL) begin
						close_tok(ttl_pkg::KIND_STRING, 1'b1);
						begin_token(c, off);
					end else
						grow_tok();
				end
				LEX_IDENT: begin
					if (is_letter(c) || is_digit(c) || c == ttl_pkg::CH_UNDERSCORE)
						grow_tok();
					else begin
						close_tok(ttl_pkg::KIND_IDENT, 1'b0);
						begin_token(c, off);
					end
				end
				LEX_NUMBER: begin
					if (is_digit(c) || c == ttl_pkg::CH_DOT)
						grow_tok();
					else begin
						close_tok(ttl_pkg::KIND_NUMBER, 1'b0);
						begin_token(c, off);
					end
				end
				LEX_UNKNOWN: begin
					// a line end closes the run and is then skipped
					if (is_eol(c))
						close_tok(ttl_pkg::KIND_UNKNOWN, 1'b0);
					else if (c == ttl_pkg::CH_NUL) begin
						close_tok(ttl_pkg::KIND_UNKNOWN, 1'b1);
						begin_token(c, off);
					end else
						grow_tok();
				end
				default: begin_token(c, off);
			endcase
			if (have_held) begin
				held.last = 1'b1;
				tokens_due.push_back(held);
				have_held = 1'b0;
			end
		end
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic logic [7:0] rand_letter();
		int r;
		r = int'($urandom_range(0, 51));
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return ttl_pkg::CH_SPACE;
			1: return ttl_pkg::CH_TAB;
			2: return ttl_pkg::CH_LF;
			default: return ttl_pkg::CH_CR;
		endcase
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	// one well-formed lexeme; closed adds the closing quote or line end
	task automatic add_lexeme(input lex_state_e what, input int n, input bit closed);
		logic [7:0] c;
		int r;
		case (what)
			LEX_IDENT: begin
				text_bytes.push_back(rand_letter());
				repeat (n - 1) begin
					r = int'($urandom_range(0, 9));
					if (r < 6)
						text_bytes.push_back(rand_letter());
					else if (r < 9)
						text_bytes.push_back(rand_digit());
					else
						text_bytes.push_back(ttl_pkg::CH_UNDERSCORE);
				end
			end
			LEX_NUMBER: begin
				text_bytes.push_back(($urandom_range(0, 4) == 0) ? ttl_pkg::CH_MINUS
					: rand_digit());
				repeat (n - 1)
					text_bytes.push_back(($urandom_range(0, 5) == 0) ? ttl_pkg::CH_DOT
						: rand_digit());
			end
			LEX_STRING: begin
				text_bytes.push_back(ttl_pkg::CH_QUOTE);
				repeat (n) begin
					do
						c = 8'($urandom_range(1, 255));
					while (c == ttl_pkg::CH_QUOTE);
					text_bytes.push_back(c);
				end
				if (closed)
					text_bytes.push_back(ttl_pkg::CH_QUOTE);
			end
			default: begin
				// first byte must fall outside every other class
				do
					c = 8'($urandom_range(1, 255));
				while (is_blank(c) || punct_kind(c) >= 0 || c == ttl_pkg::CH_QUOTE
					|| is_letter(c) || is_digit(c) || c == ttl_pkg::CH_MINUS);
				text_bytes.push_back(c);
				repeat (n - 1) begin
					do
						c = 8'($urandom_range(1, 255));
					while (is_eol(c));
					text_bytes.push_back(c);
				end
				if (closed)
					text_bytes.push_back(($urandom_range(0, 1) == 0) ? ttl_pkg::CH_LF
						: ttl_pkg::CH_CR);
			end
		endcase
	endtask

	// ---------------- stimulus and end of run ----------------

	initial begin
		int target;
		int long_mark;
		int long_len;
		int r;
		bit long_done;
		lex_state_e what;

		long_done = 1'b0;
		// every punctuation mark, then tokens closed by punctuation, quote and line end
		for (int i = 0; i < 10; i++)
			text_bytes.push_back(PUNCT_SET[79-8*i -: 8]);
		add_text("aZ_9(");
		add_text("-9.\"\"");
		text_bytes.push_back(8'hFF);
		text_bytes.push_back(8'h80);
		text_bytes.push_back(8'h7F);
		text_bytes.push_back(ttl_pkg::CH_CR);
		text_bytes.push_back(ttl_pkg::CH_LF);
		text_bytes.push_back(ttl_pkg::CH_TAB);
		add_text("7 ");

		target = text_bytes.size() + RANDOM_BYTES;
		long_mark = text_bytes.size() + int'($urandom_range(50, 900));
		while (text_bytes.size() < target) begin
			// one token long enough to saturate the length
			if (!long_done && text_bytes.size() >= long_mark) begin
				long_len = int'($urandom_range(LEN_CAP + 1, LEN_CAP + 4));
				what = lex_state_e'($urandom_range(1, 4));
				add_lexeme(what, long_len, 1'b1);
				text_bytes.push_back(rand_blank());
				target += long_len + 3;
				long_done = 1'b1;
			end
			r = int'($urandom_range(0, 99));
			if (r < 20)
				add_lexeme(LEX_IDENT, int'($urandom_range(1, 12)), 1'b1);
			else if (r < 35)
				add_lexeme(LEX_NUMBER, int'($urandom_range(1, 8)), 1'b1);
			else if (r < 50)
				add_lexeme(LEX_STRING, int'($urandom_range(0, 10)), 1'b1);
			else if (r < 65)
				text_bytes.push_back(PUNCT_SET[79-8*$urandom_range(0, 9) -: 8]);
			else if (r < 75)
				add_lexeme(LEX_UNKNOWN, int'($urandom_range(1, 10)), 1'b1);
			else if (r < 90)
				text_bytes.push_back(rand_blank());
			else
				text_bytes.push_back(8'($urandom_range(1, 255)));
			if ($urandom_range(0, 9) < 6)
				text_bytes.push_back(rand_blank());
		end

		// end of stream from a random open state, then bytes that must be dropped
		what = lex_state_e'($urandom_range(0, 4));
		if (what == LEX_IDLE)
			text_bytes.push_back(rand_blank());
		else
			add_lexeme(what, int'($urandom_range(1, 6)), 1'b0);
		text_bytes.push_back(ttl_pkg::CH_NUL);
		repeat ($urandom_range(1, 6))
			text_bytes.push_back(8'($urandom_range(0, 255)));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (text_bytes.size() != 0 || char_valid)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && tokens_due.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// ---------------- request driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_byte <= '0;
			send_wait <= 0;
			calm_in <= 0;
		end else begin
			if (char_valid && char_ready)
				lex_byte(char_byte);
			if (!char_valid || char_ready) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					char_valid <= 1'b0;
				end else if (text_bytes.size() > 0) begin
					char_byte <= text_bytes.pop_front();
					char_valid <= 1'b1;
					send_wait <= pick_gap(calm_in);
				end else
					char_valid <= 1'b0;
			end
			if (calm_in > 0)
				calm_in <= calm_in - 1;
			else if ($urandom_range(0, 299) == 0)
				calm_in <= int'($urandom_range(50, 200));
		end
	end

	// ---------------- token monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ready <= 1'b0;
			take_wait <= 0;
			calm_out <= 0;
		end else begin
			if (token_valid && token_ready) begin
				got.kind = token_kind;
				got.start = start_offset;
				got.len = token_length;
				got.unterm = unterminated;
				got.clipped = length_clipped;
				got.last = last_of_run;
				if (tokens_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected token: kind %0d start %0d len %0d",
							got.kind, got.start, got.len);
				end else begin
					want = tokens_due.pop_front();
					if (got.kind != want.kind || got.start != want.start
							|| got.len != want.len || got.unterm != want.unterm
							|| got.clipped != want.clipped || got.last != want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("token mismatch: expected kind %0d start %0d len %0d",
								want.kind, want.start, want.len);
							$write(" unterm %0b clip %0b last %0b,",
								want.unterm, want.clipped, want.last);
							$write(" got kind %0d start %0d len %0d",
								got.kind, got.start, got.len);
							$display(" unterm %0b clip %0b last %0b",
								got.unterm, got.clipped, got.last);
						end
					end
				end
				stall = pick_gap(calm_out);
				take_wait <= stall;
				token_ready <= (stall == 0);
			end else if (take_wait > 0) begin
				take_wait <= take_wait - 1;
				token_ready <= (take_wait == 1);
			end else
				token_ready <= 1'b1;
			if (calm_out > 0)
				calm_out <= calm_out - 1;
			else if ($urandom_range(0, 299) == 0)
				calm_out <= int'($urandom_range(50, 200));
		end
	end

endmodule
